### rtl/hsl_pkg.sv
// package: fixed-point constants, types and the divider step for the hsl adjust block
`default_nettype none
package hsl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FW        = FRAC_BITS + 1;
  localparam int HW        = FRAC_BITS + 5;
  localparam int RW        = 10;
  localparam int DW        = 9;
  localparam int XW        = FRAC_BITS + 8;
  localparam int K100      = FRAC_BITS + 15;
  localparam int MW100     = FRAC_BITS + 9;
  localparam int K60       = 36;
  localparam int MW60      = 31;
  localparam int DIV_STEPS = FRAC_BITS + 1;

  localparam logic [FW-1:0]    ONE    = FW'(longint'(1) << FRAC_BITS);
  localparam logic [FW+8:0]    HALF9  = (FW + 9)'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [HW-1:0] ONE_H  = HW'(longint'(1) << FRAC_BITS);
  localparam logic signed [HW-1:0] TWO_H  = HW'(longint'(2) << FRAC_BITS);
  localparam logic signed [HW-1:0] THREE_H = HW'(longint'(3) << FRAC_BITS);
  localparam logic signed [HW-1:0] FOUR_H = HW'(longint'(4) << FRAC_BITS);
  localparam logic signed [HW-1:0] SIX_H  = HW'(longint'(6) << FRAC_BITS);

  localparam logic [MW100-1:0] M100 = MW100'(((longint'(1) << K100) + 99) / 100);
  localparam logic [MW60-1:0]  M60  = MW60'(((longint'(1) << K60) + 59) / 60);

  typedef enum logic [1:0] {
    REG_HUE   = 2'd0,
    REG_SAT   = 2'd1,
    REG_LIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    HUE_RED   = 2'd0,
    HUE_GREEN = 2'd1,
    HUE_BLUE  = 2'd2
  } hue_sel_e;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] den;
    logic [FW-1:0] quot;
  } lane_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       frame_end;
    hue_sel_e   hsel;
    logic       hneg;
  } side_t;

  function automatic lane_t div_step(lane_t x, logic [RW-1:0] trial);
    lane_t y;
    y = x;
    if (trial >= {1'b0, x.den}) begin
      y.rem  = trial - {1'b0, x.den};
      y.quot = {x.quot[FW-2:0], 1'b1};
    end else begin
      y.rem  = trial;
      y.quot = {x.quot[FW-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage
`default_nettype wire

### rtl/hsl_hue_saturation_adjust.sv
// top level: pipelined rgb to hsl, hue/saturation/lightness adjust, hsl to rgb
// throughput: one pixel per cycle while the output is not stalled; the quotient bits of
// the three divisions are resolved one per stage in a shared-depth restoring divider pipeline
// reset: pipeline valid bits and the three adjust registers clear to zero
`default_nettype none
module hsl_hue_saturation_adjust import hsl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [31:0] in_pixel_i,
  input  wire logic        in_frame_end_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] out_pixel_o,
  output      logic        out_frame_end_o
);

  // configuration
  logic signed [8:0]    hue_q;
  logic signed [7:0]    sat_q, light_q;
  logic signed [HW-1:0] hshift_q, hshift_d;
  logic                 wr;
  logic signed [8:0]    hue_w, hue_s;
  logic signed [7:0]    sat_w, sat_s, light_w, light_s;
  logic [7:0]           hmag;
  logic [1:0]           hsext;
  logic [5:0]           hrem;
  logic [FRAC_BITS+5:0] hnum;
  logic [FRAC_BITS+5+MW60:0] hprod;
  logic [FRAC_BITS+1:0] hsh_mag;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    hue_w   = $signed(pwdata[8:0]);
    sat_w   = $signed(pwdata[7:0]);
    light_w = $signed(pwdata[7:0]);
    hue_s   = (hue_w < -9'sd180) ? -9'sd180 : (hue_w > 9'sd180) ? 9'sd180 : hue_w;
    sat_s   = (sat_w < -8'sd100) ? -8'sd100 : (sat_w > 8'sd100) ? 8'sd100 : sat_w;
    light_s = (light_w < -8'sd100) ? -8'sd100 : (light_w > 8'sd100) ? 8'sd100 : light_w;
    hmag    = (hue_s < 0) ? 8'(-hue_s) : 8'(hue_s);
    hsext   = (hmag >= 8'd180) ? 2'd3 : (hmag >= 8'd120) ? 2'd2 : (hmag >= 8'd60) ? 2'd1 : 2'd0;
    hrem    = 6'(hmag - 8'(hsext) * 8'd60);
    hnum    = {hrem, {FRAC_BITS{1'b0}}};
    hprod   = hnum * M60;
    hsh_mag = {hsext, {FRAC_BITS{1'b0}}} + (FRAC_BITS + 2)'(hprod[K60 +: FRAC_BITS]);
    hshift_d = (hue_s < 0) ? -$signed(HW'(hsh_mag)) : $signed(HW'(hsh_mag));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q    <= '0;
      sat_q    <= '0;
      light_q  <= '0;
      hshift_q <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_HUE: begin
          hue_q    <= hue_s;
          hshift_q <= hshift_d;
        end
        REG_SAT:   sat_q   <= sat_s;
        REG_LIGHT: light_q <= light_s;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HUE:   prdata = {{23{hue_q[8]}}, hue_q};
      REG_SAT:   prdata = {{24{sat_q[7]}}, sat_q};
      REG_LIGHT: prdata = {{24{light_q[7]}}, light_q};
      default:   prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  logic out_vld_q;
  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  // input stage
  logic        v0_q;
  logic [31:0] px0_q;
  logic        fe0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q <= in_pixel_i;
      fe0_q <= in_frame_end_i;
    end
  end

  // min, max and divider operands
  logic [7:0] r0, g0, b0, mx, mn, delta, hm;
  logic [8:0] sum, sden;
  logic       gray;
  side_t      side1_d, side1_q;
  lane_t      lane1_d [3];
  lane_t      lane1_q [3];
  logic       v1_q;

  always_comb begin
    r0    = px0_q[23:16];
    g0    = px0_q[15:8];
    b0    = px0_q[7:0];
    mx    = (r0 > g0) ? ((r0 > b0) ? r0 : b0) : ((g0 > b0) ? g0 : b0);
    mn    = (r0 < g0) ? ((r0 < b0) ? r0 : b0) : ((g0 < b0) ? g0 : b0);
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    sden  = (sum > 9'd255) ? 9'd510 - sum : sum;
    gray  = (delta == 8'd0);
    side1_d.alpha     = px0_q[31:24];
    side1_d.frame_end = fe0_q;
    if (mx == r0) begin
      side1_d.hsel = HUE_RED;
      side1_d.hneg = (g0 < b0);
      hm           = (g0 < b0) ? b0 - g0 : g0 - b0;
    end else if (mx == g0) begin
      side1_d.hsel = HUE_GREEN;
      side1_d.hneg = (b0 < r0);
      hm           = (b0 < r0) ? r0 - b0 : b0 - r0;
    end else begin
      side1_d.hsel = HUE_BLUE;
      side1_d.hneg = (r0 < g0);
      hm           = (r0 < g0) ? g0 - r0 : r0 - g0;
    end
    lane1_d[0].rem  = RW'(sum);
    lane1_d[0].den  = 9'd510;
    lane1_d[0].quot = '0;
    lane1_d[1].rem  = gray ? '0 : RW'(delta);
    lane1_d[1].den  = gray ? 9'd1 : sden;
    lane1_d[1].quot = '0;
    lane1_d[2].rem  = gray ? '0 : RW'(hm);
    lane1_d[2].den  = gray ? 9'd1 : {1'b0, delta};
    lane1_d[2].quot = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      for (int i = 0; i < 3; i++) lane1_q[i] <= lane1_d[i];
    end
  end

  // restoring divider, one quotient bit per stage for lightness, saturation and hue
  lane_t dl_q   [DIV_STEPS][3];
  side_t dside_q[DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_q;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    lane_t lin [3];
    side_t sin;
    logic  vin;
    lane_t lout [3];
    if (j == 0) begin : g_first
      assign sin = side1_q;
      assign vin = v1_q;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign lin[k]  = lane1_q[k];
        assign lout[k] = div_step(lin[k], lin[k].rem);
      end
    end else begin : g_rest
      assign sin = dside_q[j-1];
      assign vin = dv_q[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign lin[k]  = dl_q[j-1][k];
        assign lout[k] = div_step(lin[k], {lin[k].rem[RW-2:0], 1'b0});
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j] <= 1'b0;
      else if (en) dv_q[j] <= vin;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dside_q[j] <= sin;
        for (int k = 0; k < 3; k++) dl_q[j][k] <= lout[k];
      end
    end
  end

  // e1: hue assembly, saturation and lightness products
  logic [FW-1:0]        lq, sq, hf;
  side_t                sd;
  logic signed [HW-1:0] hsgn, hbase, h0;
  logic signed [8:0]    sfac_s, lneg_s;
  logic [7:0]           sfac;
  logic [6:0]           lmul;
  logic                 lpos;
  logic [FW-1:0]        lopnd;
  logic [FW+7:0]        sp_full;
  logic [XW-1:0]        sp_d, lp_d;
  logic                 v1e_q;
  logic signed [HW-1:0] h1_q;
  logic [XW-1:0]        sp1_q, lp1_q;
  logic [FW-1:0]        l1_q;
  logic                 lpos1_q;
  side_t                side_e1_q;

  always_comb begin
    lq     = dl_q[DIV_STEPS-1][0].quot;
    sq     = dl_q[DIV_STEPS-1][1].quot;
    hf     = dl_q[DIV_STEPS-1][2].quot;
    sd     = dside_q[DIV_STEPS-1];
    hsgn   = sd.hneg ? -$signed(HW'(hf)) : $signed(HW'(hf));
    case (sd.hsel)
      HUE_GREEN: hbase = TWO_H;
      HUE_BLUE:  hbase = FOUR_H;
      default:   hbase = '0;
    endcase
    h0 = hbase + hsgn;
    if (h0 < 0) h0 = h0 + SIX_H;
    sfac_s  = 9'(sat_q) + 9'sd100;
    sfac    = sfac_s[7:0];
    lneg_s  = 9'(light_q) + 9'sd100;
    lpos    = ~light_q[7];
    lmul    = lpos ? light_q[6:0] : lneg_s[6:0];
    lopnd   = lpos ? ONE - lq : lq;
    sp_full = sq * sfac;
    sp_d    = sp_full[XW-1:0];
    lp_d    = lopnd * lmul;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1e_q <= 1'b0;
    else if (en) v1e_q <= dv_q[DIV_STEPS-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_q      <= h0;
      sp1_q     <= sp_d;
      lp1_q     <= lp_d;
      l1_q      <= lq;
      lpos1_q   <= lpos;
      side_e1_q <= sd;
    end
  end

  // e2: reciprocal multiplies for the divisions by one hundred, hue rotation
  logic signed [HW-1:0] ht;
  logic                 v2_q;
  logic [XW+MW100-1:0]  sm2_q, lm2_q;
  logic signed [HW-1:0] h2_q;
  logic [FW-1:0]        l2_q;
  logic                 lpos2_q;
  side_t                side2_q;

  always_comb begin
    ht = h1_q + hshift_q;
    if (ht < 0) ht = ht + SIX_H;
    else if (ht >= SIX_H) ht = ht - SIX_H;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1e_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sm2_q   <= sp1_q * M100;
      lm2_q   <= lp1_q * M100;
      h2_q    <= ht;
      l2_q    <= l1_q;
      lpos2_q <= lpos1_q;
      side2_q <= side_e1_q;
    end
  end

  // e3: adjusted saturation and lightness
  logic [FW:0]          squot;
  logic [FW-1:0]        lquot, s3_d, l3_d;
  logic                 v3_q;
  logic [FW-1:0]        s3_q, l3_q;
  logic signed [HW-1:0] h3_q;
  side_t                side3_q;

  always_comb begin
    squot = sm2_q[K100 +: FW+1];
    lquot = lm2_q[K100 +: FW];
    s3_d  = (squot > {1'b0, ONE}) ? ONE : squot[FW-1:0];
    l3_d  = lpos2_q ? l2_q + lquot : lquot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q    <= s3_d;
      l3_q    <= l3_d;
      h3_q    <= h2_q;
      side3_q <= side2_q;
    end
  end

  // e4: l times s
  logic                 v4_q;
  logic [2*FW-1:0]      ls4_q;
  logic [FW-1:0]        s4_q, l4_q;
  logic signed [HW-1:0] h4_q;
  side_t                side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ls4_q   <= l3_q * s3_q;
      s4_q    <= s3_q;
      l4_q    <= l3_q;
      h4_q    <= h3_q;
      side4_q <= side3_q;
    end
  end

  // e5: p, q and the per-channel interpolation factor
  function automatic logic [FW-1:0] chan_factor(logic signed [HW-1:0] h,
                                                logic signed [HW-1:0] off);
    logic signed [HW-1:0] t;
    logic signed [HW-1:0] f;
    t = h + off;
    if (t < 0) t = t + SIX_H;
    else if (t >= SIX_H) t = t - SIX_H;
    if (t < ONE_H) f = t;
    else if (t < THREE_H) f = ONE_H;
    else if (t < FOUR_H) f = FOUR_H - t;
    else f = '0;
    return f[FW-1:0];
  endfunction

  logic [FW-1:0] lsr;
  logic [FW:0]   q5, p5;
  logic          v5_q;
  logic [FW-1:0] p5_q, d5_q;
  logic [FW-1:0] f5_q [3];
  side_t         side5_q;

  always_comb begin
    lsr = ls4_q[FRAC_BITS +: FW];
    if (!l4_q[FW-1] && !l4_q[FW-2]) q5 = {1'b0, l4_q} + {1'b0, lsr};
    else q5 = {1'b0, l4_q} + {1'b0, s4_q} - {1'b0, lsr};
    p5 = {l4_q, 1'b0} - q5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q    <= p5[FW-1:0];
      d5_q    <= FW'(q5 - p5);
      f5_q[0] <= chan_factor(h4_q, TWO_H);
      f5_q[1] <= chan_factor(h4_q, '0);
      f5_q[2] <= chan_factor(h4_q, -TWO_H);
      side5_q <= side4_q;
    end
  end

  // e6: interpolation products
  logic            v6_q;
  logic [2*FW-1:0] prod6_q [3];
  logic [FW-1:0]   p6_q;
  side_t           side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) prod6_q[i] <= d5_q * f5_q[i];
      p6_q    <= p5_q;
      side6_q <= side5_q;
    end
  end

  // e7: channel value times 255
  logic [FW:0]   c7 [3];
  logic          v7_q;
  logic [FW+8:0] c255_q [3];
  side_t         side7_q;

  always_comb begin
    for (int i = 0; i < 3; i++) c7[i] = {1'b0, p6_q} + {1'b0, prod6_q[i][FRAC_BITS +: FW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c255_q[i] <= {c7[i], 8'b0} - (FW + 9)'(c7[i]);
      side7_q <= side6_q;
    end
  end

  // e8: round half up, clamp, output register
  logic [FW+8:0] rnd [3];
  logic [9:0]    vb  [3];
  logic [7:0]    byte8 [3];
  logic [31:0]   out_px_q;
  logic          out_fe_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]   = c255_q[i] + HALF9;
      vb[i]    = rnd[i][FRAC_BITS +: 10];
      byte8[i] = (vb[i] > 10'd255) ? 8'd255 : vb[i][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_px_q <= {side7_q.alpha, byte8[0], byte8[1], byte8[2]};
      out_fe_q <= side7_q.frame_end;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_pixel_o     = out_px_q;
  assign out_frame_end_o = out_fe_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (lane1_q[1].den != '0) && (lane1_q[2].den != '0))
    else $error("divider operand of zero entered the pipeline");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (s3_q <= ONE) && (l3_q <= ONE))
    else $error("saturation or lightness above one");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (h3_q >= 0) && (h3_q < SIX_H))
    else $error("hue outside one turn");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> $stable(v7_q) && $stable(c255_q[0]))
    else $error("pipeline moved while the output transaction was stalled");
`endif

endmodule
`default_nettype wire

### test/testbench.sv
// testbench: random and directed pixels through the hsl adjust block, checked against a fixed-point predictor
`timescale 1ns / 1ps
module testbench;
  import hsl_pkg::*;

  localparam int ONE_I     = 1 << FRAC_BITS;
  localparam int HALF_I    = 1 << (FRAC_BITS - 1);
  localparam int SIX_I     = 6 * ONE_I;
  localparam int STALL_MAX = 2000;
  localparam int DRAIN     = FRAC_BITS + 40;

  typedef struct {
    logic [31:0] pixel;
    logic        frame_end;
  } pix_t;

  class pixel_scoreboard;
    pix_t pending[$];
    int   errors = 0;
    longint hue_deg = 0;
    longint sat_pct = 0;
    longint light_pct = 0;

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      longint x;
      case (idx)
        REG_HUE: begin
          x = longint'($signed(value[8:0]));
          hue_deg = x < -180 ? -180 : (x > 180 ? 180 : x);
        end
        REG_SAT: begin
          x = longint'($signed(value[7:0]));
          sat_pct = x < -100 ? -100 : (x > 100 ? 100 : x);
        end
        default: begin
          x = longint'($signed(value[7:0]));
          light_pct = x < -100 ? -100 : (x > 100 ? 100 : x);
        end
      endcase
    endfunction

    function longint qdiv(longint num, longint den);
      longint mag;
      mag = num < 0 ? -num : num;
      mag = (mag << FRAC_BITS) / den;
      return num < 0 ? -mag : mag;
    endfunction

    function longint tone(longint p, longint q, longint t);
      if (t < 0) t += SIX_I;
      if (t >= SIX_I) t -= SIX_I;
      if (t < ONE_I) return p + (((q - p) * t) >>> FRAC_BITS);
      if (t < 3 * ONE_I) return q;
      if (t < 4 * ONE_I) return p + (((q - p) * (4 * ONE_I - t)) >>> FRAC_BITS);
      return p;
    endfunction

    function logic [7:0] to_byte(longint c);
      longint v;
      if (c < 0) c = 0;
      v = (c * 255 + HALF_I) >>> FRAC_BITS;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function pix_t adjust(pix_t in);
      pix_t o;
      longint r, g, b, mx, mn, d, l, s, h, sh, p, q;
      logic [7:0] rr, gg, bb;
      r = in.pixel[23:16];
      g = in.pixel[15:8];
      b = in.pixel[7:0];
      mx = r > g ? (r > b ? r : b) : (g > b ? g : b);
      mn = r < g ? (r < b ? r : b) : (g < b ? g : b);
      d = mx - mn;
      l = ((mx + mn) << FRAC_BITS) / 510;
      s = 0;
      h = 0;
      if (d > 0) begin
        s = (mx + mn > 255) ? qdiv(d, 510 - mx - mn) : qdiv(d, mx + mn);
        if (mx == r) begin
          h = qdiv(g - b, d) + SIX_I;
          if (h >= SIX_I) h -= SIX_I;
        end else if (mx == g) begin
          h = qdiv(b - r, d) + 2 * ONE_I;
        end else begin
          h = qdiv(r - g, d) + 4 * ONE_I;
        end
      end
      sh = hue_deg < 0 ? -(((-hue_deg) << FRAC_BITS) / 60) : ((hue_deg << FRAC_BITS) / 60);
      h = h + sh + SIX_I;
      while (h >= SIX_I) h -= SIX_I;
      if (h < 0) h = 0;
      s = s * (100 + sat_pct) / 100;
      if (s > ONE_I) s = ONE_I;
      if (light_pct >= 0) l = l + (ONE_I - l) * light_pct / 100;
      else l = l * (100 + light_pct) / 100;
      if (s <= 0) begin
        rr = to_byte(l);
        gg = rr;
        bb = rr;
      end else begin
        q = l < HALF_I ? l + ((l * s) >>> FRAC_BITS) : l + s - ((l * s) >>> FRAC_BITS);
        p = 2 * l - q;
        rr = to_byte(tone(p, q, h + 2 * ONE_I));
        gg = to_byte(tone(p, q, h));
        bb = to_byte(tone(p, q, h - 2 * ONE_I));
      end
      o.pixel = {in.pixel[31:24], rr, gg, bb};
      o.frame_end = in.frame_end;
      return o;
    endfunction

    function void note_input(pix_t in);
      pending.push_back(adjust(in));
    endfunction

    function void check_result(pix_t got);
      pix_t exp;
      if (pending.size() == 0) begin
        $error("unexpected transaction: pixel %h", got.pixel);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.pixel !== exp.pixel) begin
        $error("out_pixel: expected %h actual %h", exp.pixel, got.pixel);
        errors++;
      end
      if (got.frame_end !== exp.frame_end) begin
        $error("out_frame_end: expected %b actual %b", exp.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] in_pixel_i;
  logic        in_frame_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] out_pixel_o;
  logic        out_frame_end_o;

  pixel_scoreboard board;
  bit  idle_on = 1;
  bit  feed_done = 0;
  int  quiet_cycles = 0;

  hsl_hue_saturation_adjust i_dut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pix_t got;
      got.pixel = out_pixel_o;
      got.frame_end = out_frame_end_o;
      board.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [31:0] px, logic fe);
    pix_t item;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_pixel_i     <= px;
    in_frame_end_i <= fe;
    do @(posedge clk_i); while (!in_ready_o);
    item.pixel = px;
    item.frame_end = fe;
    board.note_input(item);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    px = $urandom;
    case ($urandom_range(0, 5))
      0: px[15:0] = {px[23:16], px[23:16]};
      1: px[15:8] = px[23:16];
      2: px[7:0] = px[15:8];
      3: px[7:0] = px[23:16];
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    logic [31:0] dir_px[] = '{32'h00000000, 32'hFFFFFFFF, 32'h80FF0000, 32'h0100FF00,
                              32'hAA0000FF, 32'h55FFFF00, 32'h1200FFFF, 32'hFEFF00FF,
                              32'h7F808080, 32'h33FF80FF, 32'h44FFFF80, 32'h0001FE7F,
                              32'hC0C8C864, 32'h0A010203};
    int hue_set[] = '{0, 180, -180, 45, -90, 255, -256};
    int sat_set[] = '{0, 100, -100, 37, -55, 127, -128};
    int lit_set[] = '{0, 100, -100, 20, -63, 127, -128};
    int n;
    board = new();
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 0;
    in_pixel_i = '0;
    in_frame_end_i = 0;
    out_ready_i = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_px[k]) send_pixel(dir_px[k], k[0]);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 7) begin
        write_reg(REG_HUE, 32'(hue_set[ph]));
        write_reg(REG_SAT, 32'(sat_set[(ph + 2) % 7]));
        write_reg(REG_LIGHT, 32'(lit_set[(ph + 4) % 7]));
      end else begin
        write_reg(REG_HUE, $urandom);
        write_reg(REG_SAT, $urandom);
        write_reg(REG_LIGHT, $urandom);
      end
      if (ph == 9) idle_on = 0;
      n = (ph < 2) ? 8 : 78;
      for (int k = 0; k < n; k++)
        send_pixel(rand_pixel(), $urandom_range(0, 1));
      settle();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
